// ----- rtl/core/grid_flood_fill_end_to_end_macros.svh -----
// Assertion macros for the grid flood fill block.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef GRID_FLOOD_FILL_END_TO_END_MACROS_SVH
`define GRID_FLOOD_FILL_END_TO_END_MACROS_SVH

// same-cycle implication
`define GFF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GFF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/gff_pkg.sv -----
// Shared types and constants for the grid flood fill block.
// No dependencies.
`default_nettype none

package gff_pkg;

  localparam int MAX_COLS_DEF = 512;
  localparam int MAX_ROWS_DEF = 256;

  localparam int NUM_COLS_W = 10;
  localparam int NUM_ROWS_W = 9;
  localparam logic [NUM_COLS_W-1:0] NUM_COLS_RST = 10'd512;
  localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST = 9'd161;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd1;

  localparam int CNT_OUT_W = 18;
  localparam int COL_OUT_W = 9;

  localparam int CELL_W = 2;
  localparam logic [CELL_W-1:0] CELL_WALL  = 2'd0;
  localparam logic [CELL_W-1:0] CELL_FLOOR = 2'd1;
  localparam logic [CELL_W-1:0] CELL_MARK  = 2'd2;

  typedef enum logic [1:0] {
    DIR_E,
    DIR_W,
    DIR_N,
    DIR_S
  } dir_t;

  typedef struct packed {
    logic done;
    logic joined;
  } flood_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/gff_ram.sv -----
// Simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`default_nettype none

module gff_ram #(
  parameter int W = 2,
  parameter int D = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/core/gff_div.sv -----
// Restoring divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none

module gff_div #(
  parameter int NW = 18,
  parameter int DW = 9
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic      [NW-1:0] quot,
  output logic      [DW-1:0] rem,
  output logic               done
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r;
  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   quot_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   dvs_r;
  logic [DW:0]     shifted;
  logic            ge;
  logic [DW:0]     diff;

  assign shifted = {rem_r, quot_r[NW-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNTW'(NW);
      quot_r <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        rem_r  <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        quot_r <= {quot_r[NW-2:0], ge};
        cnt_r  <= cnt_r - CNTW'(1);
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

  assign done = busy_r && (cnt_r == '0);
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ----- rtl/core/gff_flood.sv -----
// Breadth-first flood sequencer: start search, queue walk, join check.
// Uses gff_pkg and gff_ram (visit queue); shares one multiply-add and one adder.
`default_nettype none

module gff_flood #(
  parameter int MAX_COLS = gff_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gff_pkg::MAX_ROWS_DEF,
  localparam int CAP = MAX_COLS * MAX_ROWS,
  localparam int AW  = $clog2(CAP),
  localparam int LW  = $clog2(CAP + 1),
  localparam int CW  = $clog2(MAX_COLS),
  localparam int RW  = $clog2(MAX_ROWS),
  localparam int CNW = $clog2(MAX_COLS + 1),
  localparam int RNW = $clog2(MAX_ROWS + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        go,
  input  wire logic [CNW-1:0]              cols,
  input  wire logic [RNW-1:0]              rows,
  input  wire logic [LW-1:0]               load_idx,
  input  wire logic [CW-1:0]               first_col,
  input  wire logic [CW-1:0]               last_col,
  output logic      [AW-1:0]               map_raddr,
  input  wire logic [gff_pkg::CELL_W-1:0]  map_rdata,
  output logic                             map_we,
  output logic      [AW-1:0]               map_waddr,
  output logic      [gff_pkg::CELL_W-1:0]  map_wdata,
  output logic      [LW-1:0]               reached,
  output gff_pkg::flood_stat_t             stat
);

  typedef enum logic [3:0] {
    F_IDLE,
    F_SBASE,
    F_SRD,
    F_SCHK,
    F_POP,
    F_UBASE,
    F_NB,
    F_NCHK,
    F_JBASE,
    F_JRD,
    F_JCHK,
    F_DONE
  } fstate_t;

  fstate_t            state_r;
  logic [LW-1:0]      base_r;
  logic [RNW-1:0]     r_r;
  logic [CW-1:0]      uc_r;
  logic [RW-1:0]      ur_r;
  gff_pkg::dir_t      k_r;
  logic [AW-1:0]      v_r;
  logic [CW-1:0]      nc_r;
  logic [RW-1:0]      nr_r;
  logic [LW-1:0]      head_r;
  logic [LW-1:0]      tail_r;
  logic [LW-1:0]      reached_r;
  logic               joined_r;

  logic [CW+RW-1:0]   q_rdata;
  logic [CW+RW-1:0]   q_wdata;
  logic               q_we;
  logic [CW-1:0]      q_col;
  logic [RW-1:0]      q_row;

  logic [CW-1:0]      mul_a;
  logic [RW-1:0]      mul_b;
  logic [LW-1:0]      base_nxt;
  logic [LW-1:0]      off;
  logic               sub;
  logic [LW-1:0]      idx_sum;
  logic               in_bnd;
  logic [CW-1:0]      nc;
  logic [RW-1:0]      nr;
  logic               idx_loaded;
  logic               floor_hit;
  logic               mark_hit;

  assign q_col = q_rdata[CW+RW-1:RW];
  assign q_row = q_rdata[RW-1:0];

  // shared multiply-add: col * rows + row
  always_comb begin
    case (state_r)
      F_UBASE: begin
        mul_a = q_col;
        mul_b = q_row;
      end
      F_JBASE: begin
        mul_a = last_col;
        mul_b = '0;
      end
      default: begin
        mul_a = first_col;
        mul_b = '0;
      end
    endcase
  end

  assign base_nxt = LW'(mul_a) * LW'(rows) + LW'(mul_b);

  // shared address adder
  always_comb begin
    off = LW'(r_r);
    sub = 1'b0;
    if (state_r == F_NB) begin
      case (k_r)
        gff_pkg::DIR_E: off = LW'(rows);
        gff_pkg::DIR_W: begin
          off = LW'(rows);
          sub = 1'b1;
        end
        gff_pkg::DIR_N: off = LW'(1);
        default: begin
          off = LW'(1);
          sub = 1'b1;
        end
      endcase
    end
  end

  assign idx_sum = sub ? (base_r - off) : (base_r + off);

  // the start cell may sit beyond the column count after a mid-grid resize
  always_comb begin
    nc = uc_r;
    nr = ur_r;
    case (k_r)
      gff_pkg::DIR_E: begin
        in_bnd = (CNW'(uc_r) + CNW'(1)) < cols;
        nc     = uc_r + CW'(1);
      end
      gff_pkg::DIR_W: begin
        in_bnd = (uc_r != '0) && (CNW'(uc_r) <= cols);
        nc     = uc_r - CW'(1);
      end
      gff_pkg::DIR_N: begin
        in_bnd = (RNW'(ur_r) + RNW'(1)) < rows;
        nr     = ur_r + RW'(1);
      end
      default: begin
        in_bnd = ur_r != '0;
        nr     = ur_r - RW'(1);
      end
    endcase
  end

  assign idx_loaded = LW'(v_r) < load_idx;
  assign floor_hit  = idx_loaded && (map_rdata == gff_pkg::CELL_FLOOR);
  assign mark_hit   = idx_loaded && (map_rdata == gff_pkg::CELL_MARK);

  assign map_raddr = idx_sum[AW-1:0];
  assign map_we    = ((state_r == F_SCHK) || (state_r == F_NCHK)) && floor_hit;
  assign map_waddr = v_r;
  assign map_wdata = gff_pkg::CELL_MARK;

  assign q_we    = map_we;
  assign q_wdata = (state_r == F_SCHK) ? {first_col, r_r[RW-1:0]} : {nc_r, nr_r};

  gff_ram #(
    .W (CW + RW),
    .D (CAP)
  ) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail_r[AW-1:0]),
    .wdata (q_wdata),
    .raddr (head_r[AW-1:0]),
    .rdata (q_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (go) begin
            head_r    <= '0;
            tail_r    <= '0;
            reached_r <= '0;
            joined_r  <= 1'b0;
            state_r   <= F_SBASE;
          end
        end
        F_SBASE: begin
          base_r  <= base_nxt;
          r_r     <= '0;
          state_r <= F_SRD;
        end
        F_SRD: begin
          if (r_r < rows) begin
            v_r     <= idx_sum[AW-1:0];
            state_r <= F_SCHK;
          end else begin
            state_r <= F_DONE;
          end
        end
        F_SCHK: begin
          if (floor_hit) begin
            tail_r    <= tail_r + LW'(1);
            reached_r <= LW'(1);
            state_r   <= F_POP;
          end else begin
            r_r     <= r_r + RNW'(1);
            state_r <= F_SRD;
          end
        end
        F_POP: begin
          if (head_r == tail_r) begin
            state_r <= F_JBASE;
          end else begin
            head_r  <= head_r + LW'(1);
            state_r <= F_UBASE;
          end
        end
        F_UBASE: begin
          uc_r    <= q_col;
          ur_r    <= q_row;
          base_r  <= base_nxt;
          k_r     <= gff_pkg::DIR_E;
          state_r <= F_NB;
        end
        F_NB: begin
          if (in_bnd) begin
            v_r     <= idx_sum[AW-1:0];
            nc_r    <= nc;
            nr_r    <= nr;
            state_r <= F_NCHK;
          end else if (k_r == gff_pkg::DIR_S) begin
            state_r <= F_POP;
          end else begin
            k_r <= gff_pkg::dir_t'(2'(k_r) + 2'd1);
          end
        end
        F_NCHK: begin
          if (floor_hit) begin
            tail_r    <= tail_r + LW'(1);
            reached_r <= reached_r + LW'(1);
          end
          if (k_r == gff_pkg::DIR_S) begin
            state_r <= F_POP;
          end else begin
            k_r     <= gff_pkg::dir_t'(2'(k_r) + 2'd1);
            state_r <= F_NB;
          end
        end
        F_JBASE: begin
          base_r  <= base_nxt;
          r_r     <= '0;
          state_r <= F_JRD;
        end
        F_JRD: begin
          if (r_r < rows) begin
            v_r     <= idx_sum[AW-1:0];
            state_r <= F_JCHK;
          end else begin
            state_r <= F_DONE;
          end
        end
        F_JCHK: begin
          if (mark_hit) begin
            joined_r <= 1'b1;
            state_r  <= F_DONE;
          end else begin
            r_r     <= r_r + RNW'(1);
            state_r <= F_JRD;
          end
        end
        F_DONE: begin
          state_r <= F_IDLE;
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

  assign reached     = reached_r;
  assign stat.done   = (state_r == F_DONE);
  assign stat.joined = joined_r;

endmodule

`default_nettype wire

// ----- rtl/core/grid_flood_fill_end_to_end.sv -----
// Top level: config registers, grid loader, cell map, flood and result register.
// Uses gff_pkg, gff_ram, gff_div, gff_flood and the assertion macro header.
//
//  channel | ports                                      | word taken when
//  --------+--------------------------------------------+-------------------
//  input   | start, busy, in_floor_present, in_last_cell | start && !busy
//  result  | out_valid, out_*                           | out_valid (1 cycle)
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data  | cfg_valid && cfg_ready
//
// A cell word within the grid size is written to the cell map as it is taken. On
// the last cell, the flood runs: the start and join checks scan the rows, and each
// reached cell and neighbor probe goes through the single cell map read port.
// A config write, and reset, run a grid size multiply, then an iterative divide
// that rebuilds the load row/column; busy is high meanwhile.
// Results are a one-cycle strobe; the receiver cannot stall.
`default_nettype none
`include "grid_flood_fill_end_to_end_macros.svh"

module grid_flood_fill_end_to_end #(
  parameter int MAX_COLS = gff_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gff_pkg::MAX_ROWS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_floor_present,
  input  wire logic                              in_last_cell,
  output logic                                   out_valid,
  output logic      [gff_pkg::CNT_OUT_W-1:0]     out_floor_cells,
  output logic      [gff_pkg::COL_OUT_W-1:0]     out_first_col,
  output logic      [gff_pkg::COL_OUT_W-1:0]     out_last_col,
  output logic      [gff_pkg::CNT_OUT_W-1:0]     out_reached_cells,
  output logic                                   out_ends_joined,
  output logic                                   out_no_floor,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [gff_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gff_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CAP = MAX_COLS * MAX_ROWS;
  localparam int AW  = $clog2(CAP);
  localparam int LW  = $clog2(CAP + 1);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CNW = $clog2(MAX_COLS + 1);
  localparam int RNW = $clog2(MAX_ROWS + 1);

  typedef enum logic [1:0] {
    T_IDLE,
    T_TOTAL,
    T_DIV,
    T_FLOOD
  } tstate_t;

  tstate_t                          state_r;
  logic [gff_pkg::NUM_COLS_W-1:0]   num_cols_r;
  logic [gff_pkg::NUM_ROWS_W-1:0]   num_rows_r;
  logic [LW-1:0]                    total_r;
  logic [LW-1:0]                    load_idx_r;
  logic [LW-1:0]                    floor_cnt_r;
  logic                             have_first_r;
  logic [CW-1:0]                    first_col_r;
  logic [CW-1:0]                    last_col_r;
  logic [CW-1:0]                    col_r;
  logic [RW-1:0]                    row_r;
  logic                             go_r;

  logic                             out_valid_r;
  logic [gff_pkg::CNT_OUT_W-1:0]    out_floor_cells_r;
  logic [gff_pkg::COL_OUT_W-1:0]    out_first_col_r;
  logic [gff_pkg::COL_OUT_W-1:0]    out_last_col_r;
  logic [gff_pkg::CNT_OUT_W-1:0]    out_reached_r;
  logic                             out_joined_r;
  logic                             out_no_floor_r;

  logic [CNW-1:0]                   cols_eff;
  logic [RNW-1:0]                   rows_eff;
  logic                             load_acc;
  logic                             load_we;
  logic                             cfg_acc;
  logic                             row_wrap;

  logic [LW-1:0]                    div_quot;
  logic [RNW-1:0]                   div_rem;
  logic                             div_done;

  logic [AW-1:0]                    fl_map_raddr;
  logic                             fl_map_we;
  logic [AW-1:0]                    fl_map_waddr;
  logic [gff_pkg::CELL_W-1:0]       fl_map_wdata;
  logic [gff_pkg::CELL_W-1:0]       map_rdata;
  logic [LW-1:0]                    fl_reached;
  gff_pkg::flood_stat_t             fl_stat;

  logic                             map_we;
  logic [AW-1:0]                    map_waddr;
  logic [gff_pkg::CELL_W-1:0]       map_wdata;

  always_comb begin
    if (num_cols_r == '0) begin
      cols_eff = CNW'(1);
    end else if (32'(num_cols_r) > MAX_COLS) begin
      cols_eff = CNW'(MAX_COLS);
    end else begin
      cols_eff = CNW'(num_cols_r);
    end
    if (num_rows_r == '0) begin
      rows_eff = RNW'(1);
    end else if (32'(num_rows_r) > MAX_ROWS) begin
      rows_eff = RNW'(MAX_ROWS);
    end else begin
      rows_eff = RNW'(num_rows_r);
    end
  end

  assign busy      = (state_r != T_IDLE);
  assign cfg_ready = (state_r == T_IDLE) && !start;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign load_acc  = start && !busy;
  assign load_we   = load_acc && (load_idx_r < total_r);
  assign row_wrap  = (RNW'(row_r) + RNW'(1)) == rows_eff;

  assign map_we    = load_we || fl_map_we;
  assign map_waddr = load_we ? load_idx_r[AW-1:0] : fl_map_waddr;
  assign map_wdata = load_we ? (in_floor_present ? gff_pkg::CELL_FLOOR : gff_pkg::CELL_WALL)
                             : fl_map_wdata;

  gff_ram #(
    .W (gff_pkg::CELL_W),
    .D (CAP)
  ) u_cell_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (fl_map_raddr),
    .rdata (map_rdata)
  );

  gff_div #(
    .NW (LW),
    .DW (RNW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == T_TOTAL),
    .dividend (load_idx_r),
    .divisor  (rows_eff),
    .quot     (div_quot),
    .rem      (div_rem),
    .done     (div_done)
  );

  gff_flood #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_flood (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go_r),
    .cols      (cols_eff),
    .rows      (rows_eff),
    .load_idx  (load_idx_r),
    .first_col (first_col_r),
    .last_col  (last_col_r),
    .map_raddr (fl_map_raddr),
    .map_rdata (map_rdata),
    .map_we    (fl_map_we),
    .map_waddr (fl_map_waddr),
    .map_wdata (fl_map_wdata),
    .reached   (fl_reached),
    .stat      (fl_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_TOTAL;
      num_cols_r   <= gff_pkg::NUM_COLS_RST;
      num_rows_r   <= gff_pkg::NUM_ROWS_RST;
      load_idx_r   <= '0;
      floor_cnt_r  <= '0;
      have_first_r <= 1'b0;
      last_col_r   <= '0;
      col_r        <= '0;
      row_r        <= '0;
      go_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      unique case (state_r)
        T_IDLE: begin
          if (cfg_acc) begin
            if (cfg_index == gff_pkg::CFG_NUM_COLS) begin
              num_cols_r <= cfg_data[gff_pkg::NUM_COLS_W-1:0];
            end else if (cfg_index == gff_pkg::CFG_NUM_ROWS) begin
              num_rows_r <= cfg_data[gff_pkg::NUM_ROWS_W-1:0];
            end
            state_r <= T_TOTAL;
          end
          if (load_we) begin
            load_idx_r <= load_idx_r + LW'(1);
            if (in_floor_present) begin
              floor_cnt_r <= floor_cnt_r + LW'(1);
              if (!have_first_r) begin
                first_col_r <= col_r;
              end
              have_first_r <= 1'b1;
              last_col_r   <= col_r;
            end
            if (row_wrap) begin
              row_r <= '0;
              col_r <= col_r + CW'(1);
            end else begin
              row_r <= row_r + RW'(1);
            end
          end
          if (load_acc && in_last_cell) begin
            if (!have_first_r && !(load_we && in_floor_present)) begin
              // empty grid
              out_valid_r       <= 1'b1;
              out_floor_cells_r <= '0;
              out_first_col_r   <= '0;
              out_last_col_r    <= '0;
              out_reached_r     <= '0;
              out_joined_r      <= 1'b0;
              out_no_floor_r    <= 1'b1;
              load_idx_r        <= '0;
              floor_cnt_r       <= '0;
              have_first_r      <= 1'b0;
              last_col_r        <= '0;
              col_r             <= '0;
              row_r             <= '0;
            end else begin
              go_r    <= 1'b1;
              state_r <= T_FLOOD;
            end
          end
        end
        T_TOTAL: begin
          total_r <= LW'(cols_eff) * LW'(rows_eff);
          state_r <= T_DIV;
        end
        T_DIV: begin
          if (div_done) begin
            col_r   <= div_quot[CW-1:0];
            row_r   <= div_rem[RW-1:0];
            state_r <= T_IDLE;
          end
        end
        T_FLOOD: begin
          if (fl_stat.done) begin
            out_valid_r       <= 1'b1;
            out_floor_cells_r <= gff_pkg::CNT_OUT_W'(floor_cnt_r);
            out_first_col_r   <= gff_pkg::COL_OUT_W'(first_col_r);
            out_last_col_r    <= gff_pkg::COL_OUT_W'(last_col_r);
            out_reached_r     <= gff_pkg::CNT_OUT_W'(fl_reached);
            out_joined_r      <= fl_stat.joined;
            out_no_floor_r    <= 1'b0;
            load_idx_r        <= '0;
            floor_cnt_r       <= '0;
            have_first_r      <= 1'b0;
            last_col_r        <= '0;
            col_r             <= '0;
            row_r             <= '0;
            state_r           <= T_IDLE;
          end
        end
        default: begin
          state_r <= T_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_floor_cells   = out_floor_cells_r;
  assign out_first_col     = out_first_col_r;
  assign out_last_col      = out_last_col_r;
  assign out_reached_cells = out_reached_r;
  assign out_ends_joined   = out_joined_r;
  assign out_no_floor      = out_no_floor_r;

  `GFF_ASSERT_NXT(a_cfg_busy, cfg_acc, busy, "config word did not start geometry rebuild")
  `GFF_ASSERT_IMP(a_strobe_cause, out_valid_r, $past(state_r == T_FLOOD) || $past(load_acc && in_last_cell), "result word without flood or last cell")
  `GFF_ASSERT_IMP(a_flood_owns_map, fl_map_we, state_r == T_FLOOD, "flood wrote cell map outside flood")
  `GFF_ASSERT_IMP(a_reach_bound, fl_stat.done, fl_reached <= floor_cnt_r, "reached count above floor count")

endmodule

`default_nettype wire
